FILE: sv/expression_token_lexer_assert.svh
// ----------------------------------------------------------------------------
// Expression token lexer assertion macros
// Shared property macros for the lexer modules. They expand to nothing
// when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef EXPRESSION_TOKEN_LEXER_ASSERT_SVH
`define EXPRESSION_TOKEN_LEXER_ASSERT_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define ETL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ETL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer assertion failed");

`else

`define ETL_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ETL_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/etl_pkg.sv
// ----------------------------------------------------------------------------
// Expression token lexer package
// Types, character codes, token kinds and classification helpers shared
// by the lexer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package etl_pkg;

    // Default width of the character position counter.
    localparam int POS_BITS_DEF = 16;

    // Token queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Saturation value of the token length.
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Token kinds.
    localparam logic [2:0] KIND_INT   = 3'd0;
    localparam logic [2:0] KIND_DEC   = 3'd1;
    localparam logic [2:0] KIND_IDENT = 3'd2;
    localparam logic [2:0] KIND_CONST = 3'd3;
    localparam logic [2:0] KIND_IMAG  = 3'd4;
    localparam logic [2:0] KIND_OPER  = 3'd5;
    localparam logic [2:0] KIND_ERROR = 3'd6;

    // Character codes.
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_P      = 8'h70;

    // Scanner modes.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_INT  = 2'd1,
        MODE_DEC  = 2'd2,
        MODE_WORD = 2'd3
    } t_mode;

    // One token as it leaves the block.
    typedef struct packed {
        logic [15:0] len;
        logic [15:0] start;
        logic [2:0]  kind;
    } t_tok;

    // All tokens caused by one character.
    typedef struct packed {
        t_tok tok0;
        t_tok tok1;
        logic two;
        logic fin;
    } t_entry;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ));
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
               (c == CH_SLASH) || (c == CH_PCT) || (c == CH_CARET) ||
               (c == CH_LPAREN) || (c == CH_RPAREN) || (c == CH_LBRACK) ||
               (c == CH_RBRACK);
    endfunction

    // Kind of the token held by a scanner mode.
    function automatic logic [2:0] mode_kind(input t_mode mode, input logic [1:0] wlen,
                                             input logic [7:0] first,
                                             input logic [7:0] second);
        logic [2:0] kind;
        kind = KIND_IDENT;
        if (mode == MODE_INT) begin
            kind = KIND_INT;
        end else if (mode == MODE_DEC) begin
            kind = KIND_DEC;
        end else if (wlen == 2'd1 && first == CH_E) begin
            kind = KIND_CONST;
        end else if (wlen == 2'd1 && first == CH_I) begin
            kind = KIND_IMAG;
        end else if (wlen == 2'd2 && first == CH_P && second == CH_I) begin
            kind = KIND_CONST;
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

FILE: sv/etl_front.sv
// ----------------------------------------------------------------------------
// Expression token lexer scanner
// Takes one character per cycle unless i_full, updates the scan mode and hands
// every token that the character completes to the token queue as one word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "expression_token_lexer_assert.svh"

module etl_front #(
    parameter int POS_BITS = etl_pkg::POS_BITS_DEF
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_char,
    input  wire                 i_final,
    output logic                o_push,
    output etl_pkg::t_entry     o_entry,
    input  wire                 i_full
);

    // Scanner state.
    etl_pkg::t_mode        r_mode, n_mode, m_mode;
    logic [POS_BITS-1:0]   r_pos, n_pos;
    logic [POS_BITS-1:0]   r_begin, m_begin;
    logic [15:0]           r_len, m_len, len_inc;
    logic [7:0]            r_first, m_first;
    logic [7:0]            r_second, m_second;
    logic [1:0]            r_wlen, m_wlen;

    logic                  accept;
    logic                  c_digit, c_letter, c_op, c_dot, c_space;
    logic                  extend;
    logic                  va, vb, vc;
    etl_pkg::t_tok         tok_a, tok_b, tok_c;

    // Positions widened so that the low 16 bits can always be taken.
    logic [POS_BITS+15:0]  pos_ext, begin_ext, mbegin_ext;

    assign pos_ext    = {16'd0, r_pos};
    assign begin_ext  = {16'd0, r_begin};
    assign mbegin_ext = {16'd0, m_begin};

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // Character classes.
    always_comb begin
        c_digit  = etl_pkg::is_digit(i_char);
        c_letter = etl_pkg::is_letter(i_char);
        c_op     = etl_pkg::is_op(i_char);
        c_dot    = (i_char == etl_pkg::CH_DOT);
        c_space  = (i_char == etl_pkg::CH_SPACE);
    end

    // Next mode and the tokens that this character emits.
    always_comb begin
        unique case (r_mode)
            etl_pkg::MODE_INT:  extend = c_digit || c_dot;
            etl_pkg::MODE_DEC:  extend = c_digit;
            etl_pkg::MODE_WORD: extend = c_digit || c_letter;
            default:            extend = 1'b0;
        endcase

        len_inc  = (r_len == etl_pkg::LEN_MAX) ? r_len : r_len + 16'd1;
        m_mode   = r_mode;
        m_begin  = r_begin;
        m_len    = r_len;
        m_first  = r_first;
        m_second = r_second;
        m_wlen   = r_wlen;

        if (extend) begin
            m_len = len_inc;
            if (r_mode == etl_pkg::MODE_INT && c_dot) begin
                m_mode = etl_pkg::MODE_DEC;
            end
            if (r_mode == etl_pkg::MODE_WORD) begin
                if (r_wlen == 2'd1) begin
                    m_second = i_char;
                end
                if (r_wlen != 2'd3) begin
                    m_wlen = r_wlen + 2'd1;
                end
            end
        end else begin
            m_mode = etl_pkg::MODE_IDLE;
            if (c_digit) begin
                m_mode  = etl_pkg::MODE_INT;
                m_begin = r_pos;
                m_len   = 16'd1;
            end else if (c_letter) begin
                m_mode   = etl_pkg::MODE_WORD;
                m_begin  = r_pos;
                m_len    = 16'd1;
                m_first  = i_char;
                m_second = 8'd0;
                m_wlen   = 2'd1;
            end
        end

        // Token ended by this character.
        va         = !extend && (r_mode != etl_pkg::MODE_IDLE);
        tok_a.kind = etl_pkg::mode_kind(r_mode, r_wlen, r_first, r_second);
        tok_a.start = begin_ext[15:0];
        tok_a.len  = r_len;

        // Operator or error character standing alone.
        vb         = !extend && !c_space && !c_digit && !c_letter;
        tok_b.kind = c_op ? etl_pkg::KIND_OPER : etl_pkg::KIND_ERROR;
        tok_b.start = pos_ext[15:0];
        tok_b.len  = 16'd1;

        // Token still open at the end of the text.
        vc         = i_final && (m_mode != etl_pkg::MODE_IDLE);
        tok_c.kind = etl_pkg::mode_kind(m_mode, m_wlen, m_first, m_second);
        tok_c.start = mbegin_ext[15:0];
        tok_c.len  = m_len;

        // Keep the first two valid tokens in order.
        o_entry.tok0 = va ? tok_a : (vb ? tok_b : tok_c);
        o_entry.tok1 = (va && vb) ? tok_b : tok_c;
        o_entry.two  = (va && vb) || (va && vc) || (vb && vc);
        o_entry.fin  = i_final;
        o_push       = accept && (va || vb || vc);

        n_mode = i_final ? etl_pkg::MODE_IDLE : m_mode;
        n_pos  = i_final ? '0 : r_pos + {{(POS_BITS-1){1'b0}}, 1'b1};
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= etl_pkg::MODE_IDLE;
            r_pos    <= '0;
            r_begin  <= '0;
            r_len    <= 16'd0;
            r_first  <= 8'd0;
            r_second <= 8'd0;
            r_wlen   <= 2'd0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_begin  <= m_begin;
            r_len    <= m_len;
            r_first  <= m_first;
            r_second <= m_second;
            r_wlen   <= m_wlen;
        end
    end

    // A word never enters the queue while it is full.
    `ETL_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, o_push, !i_full)

endmodule

`default_nettype wire

FILE: sv/etl_fifo.sv
// ----------------------------------------------------------------------------
// Expression token lexer token queue
// Short register queue of token words between the scanner and the
// output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "expression_token_lexer_assert.svh"

module etl_fifo (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  etl_pkg::t_entry  i_data,
    output logic             o_full,
    input  wire              i_pop,
    output etl_pkg::t_entry  o_data,
    output logic             o_empty
);

    // Fill count of a full queue.
    localparam logic [etl_pkg::QUEUE_AW:0] DEPTH_COUNT =
        (etl_pkg::QUEUE_AW+1)'(etl_pkg::QUEUE_DEPTH);

    etl_pkg::t_entry              r_slot [etl_pkg::QUEUE_DEPTH];
    logic [etl_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [etl_pkg::QUEUE_AW:0]   r_count;
    logic                         do_push, do_pop;

    assign o_full  = (r_count == DEPTH_COUNT);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd];

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // The fill count never runs past the depth.
    `ETL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_COUNT)

endmodule

`default_nettype wire

FILE: sv/etl_back.sv
// ----------------------------------------------------------------------------
// Expression token lexer output stage
// Takes token words from the queue and sends their tokens out one per
// word on the output stream, marking run and text ends.
// ----------------------------------------------------------------------------
`default_nettype none

`include "expression_token_lexer_assert.svh"

module etl_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  etl_pkg::t_entry  i_data,
    input  wire              i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output etl_pkg::t_tok    o_tok,
    output logic             o_run_end,
    output logic             o_text_end
);

    etl_pkg::t_entry r_entry;
    logic            r_busy;
    logic            r_idx;
    logic            last;
    logic            take;

    // Current token and its end marks.
    assign last       = r_idx || !r_entry.two;
    assign take       = r_busy && i_ready;
    assign o_valid    = r_busy;
    assign o_tok      = r_idx ? r_entry.tok1 : r_entry.tok0;
    assign o_run_end  = last;
    assign o_text_end = last && r_entry.fin;
    assign o_pop      = !i_empty && (!r_busy || (take && last));

    // Held word payload.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_entry <= i_data;
        end
    end

    // Word and token position control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 1'b0;
        end else if (take) begin
            if (last) begin
                r_busy <= 1'b0;
                r_idx  <= 1'b0;
            end else begin
                r_idx <= 1'b1;
            end
        end
    end

    // The second token is only shown for a word that carries two.
    `ETL_ASSERT_IMP(a_second_needs_two, i_clk, i_rst_n, r_busy && r_idx, r_entry.two)
    // After the first of two tokens is taken, the second one follows.
    `ETL_ASSERT_NXT(a_second_follows, i_clk, i_rst_n, take && !last, r_busy && r_idx)

endmodule

`default_nettype wire

FILE: sv/expression_token_lexer.sv
// ----------------------------------------------------------------------------
// Expression token lexer
// Splits a character stream into arithmetic expression tokens, each
// given as kind, start position and length.
// ----------------------------------------------------------------------------
//  Channel  Direction  Word                      tlast        tuser
//  s_axis   in         character                 final_char   -
//  m_axis   out        kind, start, length       text_end     run_end
//
//  One character is taken every cycle while s_axis_tready is high; the scanner
//  finishes it in that cycle. The first token of a character passes through the
//  token queue and the output stage register before it shows on m_axis.
//  The output stage sends one token per cycle while m_axis_tready is high, so
//  a character that ends a token and adds an operator or closes the text yields
//  two tokens. A four-word token queue absorbs output stalls; s_axis_tready
//  falls when it is full. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

`include "expression_token_lexer_assert.svh"

module expression_token_lexer #(
    parameter int POS_BITS = etl_pkg::POS_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // [7:0] character
    input  wire          s_axis_tlast,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [39:0]  m_axis_tdata,   // [2:0] kind, [18:3] start, [34:19] length
    output logic         m_axis_tlast,
    output logic         m_axis_tuser    // [0] run_end
);

    logic            push, full, pop, empty;
    etl_pkg::t_entry in_word, out_word;
    etl_pkg::t_tok   tok;

    // Scanner.
    etl_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_char  (s_axis_tdata),
        .i_final (s_axis_tlast),
        .o_push  (push),
        .o_entry (in_word),
        .i_full  (full)
    );

    // Token queue.
    etl_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (out_word),
        .o_empty (empty)
    );

    // Output stage.
    etl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_data     (out_word),
        .i_empty    (empty),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_tok      (tok),
        .o_run_end  (m_axis_tuser),
        .o_text_end (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, tok.len, tok.start, tok.kind};

    // The end of the text is always also the end of a run.
    `ETL_ASSERT_IMP(a_text_end_run_end, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser)

endmodule

`default_nettype wire

FILE: verif/tb_expression_token_lexer.sv
// ----------------------------------------------------------------------------
// Expression token lexer testbench
// Streams texts into the lexer one character per word and checks every
// token that comes out against a cycle-free model of the scanner kept in
// the testbench. Covers every operator, all literal and word kinds, unknown
// codes, trailing points and spaces, output stalls that back up the input,
// and one long literal.
// ----------------------------------------------------------------------------
module tb_expression_token_lexer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_DIGITS  = 120;
    localparam int MAX_REPORTS  = 10;

    localparam logic [7:0] OPER_CHARS [10] = '{etl_pkg::CH_PLUS, etl_pkg::CH_MINUS,
                                               etl_pkg::CH_STAR, etl_pkg::CH_SLASH,
                                               etl_pkg::CH_PCT, etl_pkg::CH_CARET,
                                               etl_pkg::CH_LPAREN, etl_pkg::CH_RPAREN,
                                               etl_pkg::CH_LBRACK, etl_pkg::CH_RBRACK};

    // One token as the output word carries it.
    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        run_end;
        logic        text_end;
    } lex_token_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    // Scanner copy used to work out the tokens of each character.
    etl_pkg::t_mode scan_state;
    logic [15:0] tok_origin;
    logic [15:0] next_pos;
    logic [15:0] tok_size;
    logic [7:0]  lead_char;
    logic [7:0]  second_char;
    logic [1:0]  word_chars;
    lex_token_t  step_toks [2];
    int          step_count;

    lex_token_t  pending_tokens [$];
    logic [7:0]  text_buf [$];
    int          fail_count = 0;
    int          cycle_count = 0;
    bit          src_idle_on = 1'b0;
    bit          sink_idle_on = 1'b0;
    bit          hold_request = 1'b0;
    int          hold_cycles = 0;

    always #5 i_clk = ~i_clk;

    expression_token_lexer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] character
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [2:0] kind, [18:3] start, [34:19] length
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)    // [0] run_end
    );

    function automatic bit char_is_num(logic [7:0] c);
        return c >= etl_pkg::CH_0 && c <= etl_pkg::CH_9;
    endfunction

    function automatic bit char_is_alpha(logic [7:0] c);
        return (c >= etl_pkg::CH_LA && c <= etl_pkg::CH_LZ) ||
               (c >= etl_pkg::CH_UA && c <= etl_pkg::CH_UZ);
    endfunction

    function automatic bit char_is_operator(logic [7:0] c);
        bit hit;
        hit = 1'b0;
        foreach (OPER_CHARS[k]) begin
            if (OPER_CHARS[k] == c) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void log_failure(string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%s", what);
        end
    endfunction

    // Append one character to the text being built.
    function automatic void add_char(logic [7:0] c);
        text_buf = {text_buf, c};
    endfunction

    function automatic void reset_scanner();
        scan_state  = etl_pkg::MODE_IDLE;
        tok_origin  = '0;
        next_pos    = '0;
        tok_size    = '0;
        lead_char   = '0;
        second_char = '0;
        word_chars  = '0;
    endfunction

    function automatic void emit_token(logic [2:0] kind, logic [15:0] start, logic [15:0] len);
        if (step_count < 2) begin
            step_toks[step_count] = '{kind: kind, start: start, len: len,
                                      run_end: 1'b0, text_end: 1'b0};
            step_count++;
        end
    endfunction

    function automatic void lengthen_token();
        if (tok_size != etl_pkg::LEN_MAX) begin
            tok_size++;
        end
    endfunction

    // Emit the token in progress, with the word kinds resolved by spelling.
    function automatic void close_token();
        logic [2:0] kind;
        if (scan_state == etl_pkg::MODE_IDLE) begin
            return;
        end
        case (scan_state)
            etl_pkg::MODE_INT: begin
                kind = etl_pkg::KIND_INT;
            end
            etl_pkg::MODE_DEC: begin
                kind = etl_pkg::KIND_DEC;
            end
            default: begin
                kind = etl_pkg::KIND_IDENT;
                if (word_chars == 2'd1 && lead_char == etl_pkg::CH_E) begin
                    kind = etl_pkg::KIND_CONST;
                end else if (word_chars == 2'd1 && lead_char == etl_pkg::CH_I) begin
                    kind = etl_pkg::KIND_IMAG;
                end else if (word_chars == 2'd2 && lead_char == etl_pkg::CH_P &&
                             second_char == etl_pkg::CH_I) begin
                    kind = etl_pkg::KIND_CONST;
                end
            end
        endcase
        emit_token(kind, tok_origin, tok_size);
        scan_state = etl_pkg::MODE_IDLE;
    endfunction

    // Handle a character that arrives between tokens.
    function automatic void open_token(logic [7:0] c, logic [15:0] p);
        if (c == etl_pkg::CH_SPACE) begin
            return;
        end
        if (char_is_num(c)) begin
            scan_state = etl_pkg::MODE_INT;
            tok_origin = p;
            tok_size   = 16'd1;
        end else if (char_is_alpha(c)) begin
            scan_state  = etl_pkg::MODE_WORD;
            tok_origin  = p;
            tok_size    = 16'd1;
            lead_char   = c;
            second_char = '0;
            word_chars  = 2'd1;
        end else if (char_is_operator(c)) begin
            emit_token(etl_pkg::KIND_OPER, p, 16'd1);
        end else begin
            emit_token(etl_pkg::KIND_ERROR, p, 16'd1);
        end
    endfunction

    // Advance the scanner by one accepted character and queue its tokens.
    function automatic void predict_char(logic [7:0] c, logic fin);
        logic [15:0] p;
        step_count = 0;
        p = next_pos;
        case (scan_state)
            etl_pkg::MODE_INT: begin
                if (char_is_num(c)) begin
                    lengthen_token();
                end else if (c == etl_pkg::CH_DOT) begin
                    lengthen_token();
                    scan_state = etl_pkg::MODE_DEC;
                end else begin
                    close_token();
                    open_token(c, p);
                end
            end
            etl_pkg::MODE_DEC: begin
                if (char_is_num(c)) begin
                    lengthen_token();
                end else begin
                    close_token();
                    open_token(c, p);
                end
            end
            etl_pkg::MODE_WORD: begin
                if (char_is_num(c) || char_is_alpha(c)) begin
                    lengthen_token();
                    if (word_chars == 2'd1) begin
                        second_char = c;
                    end
                    if (word_chars != 2'd3) begin
                        word_chars++;
                    end
                end else begin
                    close_token();
                    open_token(c, p);
                end
            end
            default: begin
                open_token(c, p);
            end
        endcase
        next_pos = p + 16'd1;
        if (fin) begin
            close_token();
            scan_state = etl_pkg::MODE_IDLE;
            next_pos   = '0;
        end
        if (step_count > 0) begin
            step_toks[step_count - 1].run_end  = 1'b1;
            step_toks[step_count - 1].text_end = fin;
        end
        for (int k = 0; k < step_count; k++) begin
            pending_tokens = {pending_tokens, step_toks[k]};
        end
    endfunction

    // Offer one character, optionally after a random gap, and wait for it to be taken.
    task automatic send_char(logic [7:0] c, logic fin);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_char(c, fin);
    endtask

    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++) begin
            send_char(text_buf[k], k == text_buf.size() - 1);
        end
    endtask

    task automatic push_string(string s);
        for (int k = 0; k < s.len(); k++) begin
            add_char(s[k]);
        end
    endtask

    // Stop offering characters and wait until every predicted token has come.
    task automatic wait_for_tokens();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_tokens.size() != 0);
    endtask

    function automatic logic [7:0] rand_digit();
        return etl_pkg::CH_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? etl_pkg::CH_LA : etl_pkg::CH_UA) +
               8'($urandom_range(0, 25));
    endfunction

    // A code the lexer cannot place, with the point picked often.
    function automatic logic [7:0] rand_stray();
        logic [7:0] c;
        if ($urandom_range(0, 2) == 0) begin
            return etl_pkg::CH_DOT;
        end
        do begin
            c = 8'($urandom_range(0, 255));
        end while (char_is_num(c) || char_is_alpha(c) || char_is_operator(c) ||
                   c == etl_pkg::CH_SPACE);
        return c;
    endfunction

    // Build an expression from random tokens, or a run of random bytes now and then.
    task automatic build_text();
        int n_tok;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) add_char(8'($urandom_range(0, 255)));
            return;
        end
        n_tok = $urandom_range(1, 8);
        repeat (n_tok) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    repeat ($urandom_range(1, 4)) add_char(rand_digit());
                end
                2: begin
                    repeat ($urandom_range(1, 3)) add_char(rand_digit());
                    add_char(etl_pkg::CH_DOT);
                    repeat ($urandom_range(0, 3)) add_char(rand_digit());
                end
                3: begin
                    add_char(rand_letter());
                    repeat ($urandom_range(0, 4)) begin
                        add_char($urandom_range(0, 2) ? rand_letter() : rand_digit());
                    end
                end
                4: begin
                    case ($urandom_range(0, 4))
                        0: push_string("pi");
                        1: push_string("e");
                        2: push_string("i");
                        3: push_string("Pi");
                        default: push_string("p");
                    endcase
                end
                7: begin
                    add_char(rand_stray());
                end
                default: begin
                    add_char(OPER_CHARS[$urandom_range(0, 9)]);
                end
            endcase
            repeat ($urandom_range(0, 2)) add_char(etl_pkg::CH_SPACE);
        end
    endtask

    // Every operator in one text.
    task automatic test_operator_chars();
        text_buf.delete();
        foreach (OPER_CHARS[k]) begin
            add_char(OPER_CHARS[k]);
        end
        send_text();
    endtask

    // Trailing point, second point, upper-case word with a digit, and pi at the end.
    task automatic test_literal_edges();
        text_buf.delete();
        push_string("3..E1 pi");
        send_text();
    endtask

    // Digit then letter, the lowest and highest codes, and a text ending in spaces.
    task automatic test_unknown_and_trailing();
        text_buf.delete();
        push_string("7e");
        add_char(8'hFF);
        add_char(8'h00);
        push_string("i  ");
        send_text();
    endtask

    task automatic test_random_texts(int target, bit with_idle);
        int sent;
        sent = 0;
        sink_idle_on = with_idle;
        while (sent < target) begin
            src_idle_on = with_idle && ($urandom_range(0, 3) != 0);
            text_buf.delete();
            build_text();
            send_text();
            sent += text_buf.size();
        end
        src_idle_on = 1'b0;
    endtask

    // The receiver holds off while operators keep coming, so the token queue fills.
    task automatic test_output_stall();
        src_idle_on  = 1'b0;
        hold_cycles  = 80;
        hold_request = 1'b1;
        text_buf.delete();
        repeat (24) add_char(OPER_CHARS[$urandom_range(0, 9)]);
        send_text();
        wait_for_tokens();
    endtask

    // One long literal followed by an operator and a constant.
    task automatic test_long_literal();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        text_buf.delete();
        repeat (LONG_DIGITS) add_char(rand_digit());
        add_char(etl_pkg::CH_PLUS);
        push_string("pi");
        send_text();
    endtask

    // Receiver side: random stalls, plus one long hold-off on request.
    initial begin : sink_driver
        while (!i_rst_n) begin
            @(posedge i_clk);
        end
        forever begin
            if (hold_request) begin
                m_axis_tready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_request = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Compare each accepted token with the oldest one predicted.
    always @(posedge i_clk) begin : token_monitor
        lex_token_t seen;
        lex_token_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = '{kind: m_axis_tdata[2:0], start: m_axis_tdata[18:3],
                     len: m_axis_tdata[34:19], run_end: m_axis_tuser,
                     text_end: m_axis_tlast};
            if (pending_tokens.size() == 0) begin
                log_failure($sformatf("unexpected token: kind %0d start %0d len %0d",
                                      seen.kind, seen.start, seen.len));
            end else begin
                want = pending_tokens.pop_front();
                if (seen !== want) begin
                    log_failure($sformatf(
                        {"token mismatch: expected kind %0d start %0d len %0d run %0b",
                         " end %0b, got kind %0d start %0d len %0d run %0b end %0b"},
                        want.kind, want.start, want.len, want.run_end, want.text_end,
                        seen.kind, seen.start, seen.len, seen.run_end, seen.text_end));
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[expression_token_lexer] ERROR");
            $finish;
        end
    end

    initial begin
        reset_scanner();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_operator_chars();
        test_literal_edges();
        test_unknown_and_trailing();
        test_random_texts(1450, 1'b1);
        test_output_stall();
        test_long_literal();
        test_random_texts(300, 1'b0);

        wait_for_tokens();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_tokens.size() != 0) begin
            log_failure($sformatf("%0d tokens never arrived", pending_tokens.size()));
        end
        if (fail_count == 0) begin
            $display("[expression_token_lexer] OK");
        end else begin
            $display("[expression_token_lexer] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/etl_pkg.sv
sv/etl_front.sv
sv/etl_fifo.sv
sv/etl_back.sv
sv/expression_token_lexer.sv
verif/tb_expression_token_lexer.sv
